// File: hdl/xld_pkg.sv
`timescale 1ns / 1ps

package xld_pkg;

  localparam int NUM_BYTES = 15;   // instruction window depth
  localparam int WIN_BYTES = 7;    // bytes the final decode looks at
  localparam int POS_W     = 4;
  localparam int END_W     = 5;
  localparam int IN_W      = 8 * NUM_BYTES;
  localparam int OUT_W     = 16;

  typedef logic [7:0] ibyte_t;

  localparam ibyte_t OP_VEX2      = 8'hC5;
  localparam ibyte_t OP_VEX3      = 8'hC4;
  localparam ibyte_t OP_EVEX      = 8'h62;
  localparam ibyte_t OP_ESC       = 8'h0F;
  localparam ibyte_t REX_LO       = 8'h40;
  localparam ibyte_t REX_HI       = 8'h4F;
  localparam ibyte_t OP_GRP1_I8   = 8'h80;
  localparam ibyte_t OP_GRP1_I32  = 8'h81;
  localparam ibyte_t OP_GRP1_SI8  = 8'h83;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [3:0] len;
    logic       base_valid;
    logic [3:0] base_reg;
  } dec_t;

  function automatic logic is_vex_lead(input ibyte_t v);
    return v == OP_VEX2 || v == OP_VEX3 || v == OP_EVEX;
  endfunction

  function automatic logic is_legacy_prefix(input ibyte_t v);
    return v == 8'h66 || v == 8'h67 || v == 8'hF2 || v == 8'hF3 ||
           v == 8'h26 || v == 8'h2E || v == 8'h36 || v == 8'h3E ||
           v == 8'h64 || v == 8'h65;
  endfunction

  function automatic logic is_rex(input ibyte_t v);
    return v >= REX_LO && v <= REX_HI;
  endfunction

  function automatic logic has_one_byte_modrm(input ibyte_t op);
    return op <= 8'h03 ||
           (op >= 8'h08 && op <= 8'h0B) ||
           (op >= 8'h20 && op <= 8'h23) ||
           (op >= 8'h28 && op <= 8'h2B) ||
           (op >= 8'h30 && op <= 8'h33) ||
           (op >= 8'h38 && op <= 8'h3B) ||
           (op >= 8'h80 && op <= 8'h83) ||
           op == 8'h85 || op == 8'h87 || op == 8'h89 || op == 8'h8B ||
           op == 8'h8D || op == 8'hFF;
  endfunction

endpackage

// File: hdl/xld_cell.sv
`timescale 1ns / 1ps

module xld_cell (
  input  logic            clk,
  input  logic            load,
  input  logic            shift,
  input  xld_pkg::ibyte_t load_byte,
  input  xld_pkg::ibyte_t next_byte,
  output xld_pkg::ibyte_t q
);
  import xld_pkg::*;

  ibyte_t byte_r;
  ibyte_t byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (load) begin
      byte_nxt = load_byte;
    end else if (shift) begin
      byte_nxt = next_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign q = byte_r;

endmodule

// File: hdl/xld_decode.sv
`timescale 1ns / 1ps

module xld_decode (
  input  xld_pkg::ibyte_t               win [xld_pkg::WIN_BYTES],
  input  logic [xld_pkg::POS_W-1:0]     pos,
  output xld_pkg::dec_t                 dec
);
  import xld_pkg::*;

  logic             vex;
  logic             rex;
  ibyte_t           op;
  logic             twob;
  logic             known;
  logic [2:0]       m;
  ibyte_t           modrm;
  ibyte_t           sib;
  logic [END_W-1:0] mpos;
  logic             pos_ok;
  logic [1:0]       md;
  logic [2:0]       rm;
  logic             has_sib;
  logic [2:0]       disp;
  logic [2:0]       imm;
  logic [END_W-1:0] end_pos;
  logic             hi;
  logic             bvalid;

  always_comb begin
    vex  = (pos == '0) && is_vex_lead(win[0]);
    rex  = !vex && is_rex(win[0]);
    op   = rex ? win[1] : win[0];
    twob = !vex && (op == OP_ESC);
    known = vex || twob || has_one_byte_modrm(op);

    // relative index of the ModR/M byte inside the window
    if (vex) begin
      unique case (win[0])
        OP_VEX2: m = 3'd3;
        OP_VEX3: m = 3'd4;
        default: m = 3'd5;
      endcase
    end else begin
      m = 3'd1 + {2'b00, rex} + {2'b00, twob};
    end

    unique case (m)
      3'd1:    begin modrm = win[1]; sib = win[2]; end
      3'd2:    begin modrm = win[2]; sib = win[3]; end
      3'd3:    begin modrm = win[3]; sib = win[4]; end
      3'd4:    begin modrm = win[4]; sib = win[5]; end
      3'd5:    begin modrm = win[5]; sib = win[6]; end
      default: begin modrm = win[1]; sib = win[2]; end
    endcase

    mpos   = {1'b0, pos} + {2'b00, m};
    pos_ok = mpos < END_W'(NUM_BYTES);
    md     = modrm[7:6];
    rm     = modrm[2:0];

    has_sib = (rm == 3'd4) && (md != 2'd3);
    if ((md == 2'd0 && rm == 3'd5) || md == 2'd2) begin
      disp = 3'd4;
    end else if (md == 2'd1) begin
      disp = 3'd1;
    end else begin
      disp = 3'd0;
    end

    imm = 3'd0;
    if (!vex && !twob) begin
      if (op == OP_GRP1_I8 || op == OP_GRP1_SI8) begin
        imm = 3'd1;
      end else if (op == OP_GRP1_I32) begin
        imm = 3'd4;
      end
    end

    end_pos = mpos + END_W'(1) + {{(END_W-1){1'b0}}, has_sib}
            + {2'b00, disp} + {2'b00, imm};

    if (known && pos_ok && end_pos <= END_W'(NUM_BYTES)) begin
      dec.len = end_pos[3:0];
    end else begin
      dec.len = '0;
    end

    // B extension: inverted in VEX3/EVEX byte 1, absent in VEX2, REX.B otherwise
    if (vex) begin
      hi = (win[0] != OP_VEX2) && !win[1][5];
    end else begin
      hi = rex && win[0][0];
    end

    if (!pos_ok || md == 2'd3) begin
      bvalid = 1'b0;
    end else if (rm == 3'd4) begin
      bvalid = (mpos < END_W'(NUM_BYTES - 1)) && !(sib[2:0] == 3'd5 && md == 2'd0);
    end else begin
      bvalid = !(rm == 3'd5 && md == 2'd0);
    end

    dec.base_valid = bvalid;
    if (!bvalid) begin
      dec.base_reg = '0;
    end else if (rm == 3'd4) begin
      dec.base_reg = {hi, sib[2:0]};
    end else begin
      dec.base_reg = {hi, rm};
    end
  end

endmodule

// File: hdl/x64_instruction_length_decoder.sv
`timescale 1ns / 1ps

// Length and memory-base decoder for one x64 instruction held in a 15-byte
// window. The bytes sit in a row of byte cells; each cycle the row shifts
// one place toward the head while the head byte is a legacy prefix, then a
// single pass over the head of the row decodes REX/VEX/EVEX, opcode,
// ModR/M, SIB, displacement and immediate. The result is registered when the
// walk over the N leading legacy prefixes (0..15) ends and the output register
// is free, and the input reopens as it is registered, so a new item is taken only
// after the last one is done and the prefix walk through the cell row sets the rate.
// Length 0 flags an unknown opcode or an instruction that runs past byte 14.
// The result sits in an output register, so the next item is taken while it
// waits.
module x64_instruction_length_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [xld_pkg::IN_W-1:0]   in_tdata,   // bytes_low[63:0], bytes_high[119:64]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [xld_pkg::OUT_W-1:0]  out_tdata   // insn_length[3:0], base_valid[4],
                                                 // base_reg[8:5], is_vex[9], zero[15:10]
);
  import xld_pkg::*;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             is_vex_r, is_vex_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  ibyte_t byte_q [NUM_BYTES];
  ibyte_t win    [WIN_BYTES];
  ibyte_t head;
  logic   load;
  logic   step;
  logic   finish;
  logic   out_free;
  dec_t   dec;

  genvar gi;
  generate
    for (gi = 0; gi < NUM_BYTES; gi++) begin : g_cell
      ibyte_t nb;
      if (gi == NUM_BYTES - 1) begin : g_tail
        assign nb = '0;
      end else begin : g_mid
        assign nb = byte_q[gi+1];
      end
      xld_cell u_cell (
        .clk       (clk),
        .load      (load),
        .shift     (step),
        .load_byte (in_tdata[8*gi +: 8]),
        .next_byte (nb),
        .q         (byte_q[gi])
      );
    end
    for (gi = 0; gi < WIN_BYTES; gi++) begin : g_win
      assign win[gi] = byte_q[gi];
    end
  endgenerate

  assign head = byte_q[0];

  xld_decode u_decode (
    .win (win),
    .pos (pos_r),
    .dec (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      is_vex_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      is_vex_r    <= is_vex_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    is_vex_nxt    = is_vex_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    out_free  = !out_valid_r || out_tready;
    in_tready = (state_r == ST_IDLE);
    load      = in_tvalid && in_tready;

    // prefix walk: a VEX/EVEX lead at byte 0 is never treated as a prefix
    step   = (state_r == ST_SCAN)
           && !((pos_r == '0) && is_vex_lead(head))
           && (pos_r != POS_W'(NUM_BYTES))
           && is_legacy_prefix(head);
    finish = (state_r == ST_SCAN) && !step;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (load) begin
          state_nxt  = ST_SCAN;
          pos_nxt    = '0;
          is_vex_nxt = is_vex_lead(in_tdata[7:0]);
        end
      end
      ST_SCAN: begin
        if (step) begin
          pos_nxt = pos_r + POS_W'(1);
        end else if (finish && out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, is_vex_r, dec.base_reg, dec.base_valid, dec.len};
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_vex_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && pos_r != '0) |-> !is_vex_r)
    else $error("prefix walk advanced on a VEX/EVEX transaction");

  a_load_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_SCAN && pos_r == '0))
    else $error("accepted transaction did not start a scan at byte 0");

  a_no_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[4]) |-> (out_tdata[8:5] == 4'd0))
    else $error("base_reg nonzero without base_valid");

  a_vex_min_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[9] && out_tdata[3:0] != 4'd0) |-> (out_tdata[3:0] >= 4'd4))
    else $error("VEX/EVEX length shorter than its fixed bytes");
`endif

endmodule

// File: tb/x64_instruction_length_decoder_tb.sv
`timescale 1ns / 1ps

module x64_instruction_length_decoder_tb;
  import xld_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = NUM_BYTES + 10;
  localparam int MAX_REPORTS     = 30;

  // legacy prefixes
  localparam ibyte_t PFX_OPSZ  = 8'h66;
  localparam ibyte_t PFX_ADSZ  = 8'h67;
  localparam ibyte_t PFX_REPNE = 8'hF2;
  localparam ibyte_t PFX_REP   = 8'hF3;
  localparam ibyte_t PFX_ES    = 8'h26;
  localparam ibyte_t PFX_CS    = 8'h2E;
  localparam ibyte_t PFX_SS    = 8'h36;
  localparam ibyte_t PFX_DS    = 8'h3E;
  localparam ibyte_t PFX_FS    = 8'h64;
  localparam ibyte_t PFX_GS    = 8'h65;

  // one-byte opcodes with ModR/M (group bases cover four opcodes each)
  localparam ibyte_t OP_ADD    = 8'h00;
  localparam ibyte_t OP_OR     = 8'h08;
  localparam ibyte_t OP_AND    = 8'h20;
  localparam ibyte_t OP_SUB    = 8'h28;
  localparam ibyte_t OP_XOR    = 8'h30;
  localparam ibyte_t OP_CMP    = 8'h38;
  localparam ibyte_t OP_TEST   = 8'h85;
  localparam ibyte_t OP_XCHG   = 8'h87;
  localparam ibyte_t OP_MOV_ST = 8'h89;
  localparam ibyte_t OP_MOV_LD = 8'h8B;
  localparam ibyte_t OP_LEA    = 8'h8D;
  localparam ibyte_t OP_GRP5   = 8'hFF;
  localparam ibyte_t OP_NOP    = 8'h90;   // not in the decoded set

  typedef struct packed {
    logic [3:0] len;
    logic       base_valid;
    logic [3:0] base_reg;
    logic       is_vex;
  } decode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;

  logic [IN_W-1:0]   fetch_q[$];
  decode_t           predicted_decodes[$];
  decode_t           want, got;
  logic              in_fire = 1'b0;
  logic              hold_long = 1'b0;
  int                hold_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                items_queued = 0;
  int                results_seen = 0;
  int                mismatch_count = 0;
  int                quiet_cycles = 0;
  int                n_vex = 0;
  int                n_based = 0;
  int                n_zero_len = 0;

  x64_instruction_length_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // ---------------- predictor ----------------

  function automatic ibyte_t byte_at(input logic [IN_W-1:0] w, input int idx);
    if (idx >= NUM_BYTES) return '0;
    return w[idx*8 +: 8];
  endfunction

  function automatic logic prefix_byte(input ibyte_t v);
    case (v)
      PFX_OPSZ, PFX_ADSZ, PFX_REPNE, PFX_REP, PFX_ES,
      PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic rex_byte(input ibyte_t v);
    return v >= REX_LO && v <= REX_HI;
  endfunction

  function automatic logic takes_modrm(input ibyte_t op);
    return op <= OP_ADD + 3 ||
           (op >= OP_OR  && op <= OP_OR  + 3) ||
           (op >= OP_AND && op <= OP_AND + 3) ||
           (op >= OP_SUB && op <= OP_SUB + 3) ||
           (op >= OP_XOR && op <= OP_XOR + 3) ||
           (op >= OP_CMP && op <= OP_CMP + 3) ||
           (op >= OP_GRP1_I8 && op <= OP_GRP1_SI8) ||
           op == OP_TEST || op == OP_XCHG || op == OP_MOV_ST ||
           op == OP_MOV_LD || op == OP_LEA || op == OP_GRP5;
  endfunction

  // end offset of ModR/M + SIB + displacement starting at pos, 0 past the window
  function automatic int operand_end(input logic [IN_W-1:0] w, input int pos);
    ibyte_t mrm;
    int     stop;
    if (pos >= NUM_BYTES) return 0;
    mrm  = byte_at(w, pos);
    stop = pos + 1;
    if (mrm[2:0] == 3'd4 && mrm[7:6] != 2'd3) stop++;
    if (mrm[7:6] == 2'd0 && mrm[2:0] == 3'd5) stop += 4;
    else if (mrm[7:6] == 2'd1) stop += 1;
    else if (mrm[7:6] == 2'd2) stop += 4;
    return stop;
  endfunction

  function automatic int insn_length_of(input logic [IN_W-1:0] w);
    ibyte_t lead, op;
    int     p, stop;
    p    = 0;
    lead = byte_at(w, 0);
    if (lead == OP_VEX2) stop = operand_end(w, 3);
    else if (lead == OP_VEX3) stop = operand_end(w, 4);
    else if (lead == OP_EVEX) stop = operand_end(w, 5);
    else begin
      while (p < NUM_BYTES && prefix_byte(byte_at(w, p))) p++;
      if (p >= NUM_BYTES) return 0;
      if (rex_byte(byte_at(w, p))) p++;
      if (p >= NUM_BYTES) return 0;
      op = byte_at(w, p);
      p++;
      if (op == OP_ESC) stop = operand_end(w, p + 1);
      else if (takes_modrm(op)) begin
        stop = operand_end(w, p);
        if (stop == 0) return 0;
        if (op == OP_GRP1_I8 || op == OP_GRP1_SI8) stop += 1;
        else if (op == OP_GRP1_I32) stop += 4;
      end else begin
        return 0;
      end
    end
    if (stop > NUM_BYTES) return 0;
    return stop;
  endfunction

  // -1 when no memory base is named
  function automatic int mem_base_of(input logic [IN_W-1:0] w);
    ibyte_t lead, cur, mrm;
    int     p, hi;
    p    = 0;
    hi   = 0;
    lead = byte_at(w, 0);
    if (lead == OP_VEX2) begin
      p = 3;
    end else if (lead == OP_VEX3 || lead == OP_EVEX) begin
      cur = byte_at(w, 1);
      hi  = cur[5] ? 0 : 8;   // B is stored inverted
      p   = (lead == OP_VEX3) ? 4 : 5;
    end else begin
      while (p < NUM_BYTES && prefix_byte(byte_at(w, p))) p++;
      if (p >= NUM_BYTES) return -1;
      cur = byte_at(w, p);
      if (rex_byte(cur)) begin
        hi = cur[0] ? 8 : 0;
        p++;
      end
      if (p >= NUM_BYTES) return -1;
      if (byte_at(w, p) == OP_ESC) p++;
      p++;
    end
    if (p >= NUM_BYTES) return -1;
    mrm = byte_at(w, p);
    if (mrm[7:6] == 2'd3) return -1;
    if (mrm[2:0] == 3'd4) begin
      if (p + 1 >= NUM_BYTES) return -1;
      cur = byte_at(w, p + 1);
      if (cur[2:0] == 3'd5 && mrm[7:6] == 2'd0) return -1;
      return cur[2:0] + hi;
    end
    if (mrm[2:0] == 3'd5 && mrm[7:6] == 2'd0) return -1;
    return mrm[2:0] + hi;
  endfunction

  function automatic decode_t predict_decode(input logic [IN_W-1:0] w);
    decode_t d;
    int      base;
    ibyte_t  lead;
    base         = mem_base_of(w);
    lead         = byte_at(w, 0);
    d.len        = 4'(insn_length_of(w));
    d.base_valid = base >= 0;
    d.base_reg   = base >= 0 ? base[3:0] : 4'd0;
    d.is_vex     = lead == OP_VEX2 || lead == OP_VEX3 || lead == OP_EVEX;
    return d;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic ibyte_t pick_prefix(input int k);
    case (k)
      0: return PFX_OPSZ;
      1: return PFX_ADSZ;
      2: return PFX_REPNE;
      3: return PFX_REP;
      4: return PFX_ES;
      5: return PFX_CS;
      6: return PFX_SS;
      7: return PFX_DS;
      8: return PFX_FS;
      default: return PFX_GS;
    endcase
  endfunction

  function automatic ibyte_t pick_listed_op();
    ibyte_t r;
    r = ibyte_t'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0: return OP_ADD + r;
      1: return OP_OR + r;
      2: return OP_AND + r;
      3: return OP_SUB + r;
      4: return OP_XOR + r;
      5: return OP_CMP + r;
      6: return OP_GRP1_I8 + r;
      default: begin
        case ($urandom_range(0, 5))
          0: return OP_TEST;
          1: return OP_XCHG;
          2: return OP_MOV_ST;
          3: return OP_MOV_LD;
          4: return OP_LEA;
          default: return OP_GRP5;
        endcase
      end
    endcase
  endfunction

  // n_pfx prefixes, then n_tail bytes of tail (first byte in the top), rest random
  function automatic logic [IN_W-1:0] build(input int n_pfx, input logic [IN_W-1:0] tail,
                                            input int n_tail);
    logic [IN_W-1:0] w;
    int              i;
    w = IN_W'({$urandom, $urandom, $urandom, $urandom});
    for (i = 0; i < n_pfx; i++) w[i*8 +: 8] = pick_prefix(i % 10);
    for (i = 0; i < n_tail && n_pfx + i < NUM_BYTES; i++)
      w[(n_pfx+i)*8 +: 8] = tail[(n_tail-1-i)*8 +: 8];
    return w;
  endfunction

  function automatic logic [IN_W-1:0] random_insn();
    logic [IN_W-1:0] w;
    int              form, p, n_pfx, i;
    ibyte_t          op;
    w    = IN_W'({$urandom, $urandom, $urandom, $urandom});
    form = $urandom_range(0, 99);
    if (form < 10) return w;   // raw noise
    if (form < 16) begin
      w[7:0] = OP_VEX2;
      return w;
    end
    if (form < 22) begin
      w[7:0] = OP_VEX3;
      return w;
    end
    if (form < 28) begin
      w[7:0] = OP_EVEX;
      return w;
    end
    // mostly short prefix runs, occasionally long ones up to the full window
    n_pfx = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(0, NUM_BYTES);
    for (i = 0; i < n_pfx; i++) w[i*8 +: 8] = pick_prefix($urandom_range(0, 9));
    p = n_pfx;
    if (p < NUM_BYTES && $urandom_range(0, 1)) begin
      w[p*8 +: 8] = REX_LO + ibyte_t'($urandom_range(0, 15));
      p++;
    end
    case ($urandom_range(0, 19))
      0, 1, 2: op = OP_ESC;
      3, 4:    op = ibyte_t'($urandom);
      default: op = pick_listed_op();
    endcase
    if (p < NUM_BYTES) w[p*8 +: 8] = op;
    return w;
  endfunction

  task automatic add_item(input logic [IN_W-1:0] w);
    fetch_q.push_back(w);
    items_queued++;
  endtask

  task automatic wait_drained();
    while (results_seen != items_queued) @(negedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n);
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) add_item(random_insn());
    wait_drained();
  endtask

  task automatic flag_mismatch(input string what, input int got_v, input int want_v);
    if (mismatch_count < MAX_REPORTS)
      $display("MISMATCH result %0d: %s got %0d expected %0d", results_seen, what, got_v,
               want_v);
    mismatch_count++;
  endtask

  // ---------------- driver / receiver ----------------

  always @(negedge clk) begin
    if (!in_tvalid || in_fire) begin
      if (fetch_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tdata  <= fetch_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_long && hold_count < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      hold_count++;
    end else begin
      out_tready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  // ---------------- monitor / checker ----------------

  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        want = predict_decode(in_tdata);
        predicted_decodes.push_back(want);
        n_vex      += int'(want.is_vex);
        n_based    += int'(want.base_valid);
        n_zero_len += int'(want.len == 4'd0);
      end
      if (out_tvalid && out_tready) begin
        got.len        = out_tdata[3:0];
        got.base_valid = out_tdata[4];
        got.base_reg   = out_tdata[8:5];
        got.is_vex     = out_tdata[9];
        if (predicted_decodes.size() == 0) begin
          flag_mismatch("unexpected transaction, len", int'(got.len), 0);
        end else begin
          want = predicted_decodes.pop_front();
          if (got.len !== want.len)
            flag_mismatch("insn_length", int'(got.len), int'(want.len));
          if (got.base_valid !== want.base_valid)
            flag_mismatch("base_valid", int'(got.base_valid), int'(want.base_valid));
          if (got.base_reg !== want.base_reg)
            flag_mismatch("base_reg", int'(got.base_reg), int'(want.base_reg));
          if (got.is_vex !== want.is_vex)
            flag_mismatch("is_vex", int'(got.is_vex), int'(want.is_vex));
        end
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_CYCLES);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each form, field extremes and the corner cases
    add_item(build(0, IN_W'({OP_VEX2, 8'hF8, 8'h58, 8'h00}), 4));
    add_item(build(0, IN_W'({OP_VEX3, 8'hC2, 8'h79, 8'h58, 8'h44, 8'h24, 8'h10}), 7)); // B inv
    add_item(build(0, IN_W'({OP_VEX3, 8'hE2, 8'h79, 8'h58, 8'hC1}), 5));          // reg direct
    add_item(build(0, IN_W'({OP_EVEX, 8'hF1, 8'h7C, 8'h48, 8'h58, 8'h85}), 6));   // disp32
    add_item(build(0, IN_W'({OP_EVEX, 8'h51, 8'h7C, 8'h48, 8'h58, 8'h4B}), 6));
    add_item(build(0, IN_W'({OP_ADD, 8'hC0}), 2));
    add_item(build(0, IN_W'({REX_LO | 8'h09, OP_MOV_LD, 8'h03}), 3));
    add_item(build(0, IN_W'({OP_LEA, 8'h05}), 2));                                // RIP relative
    add_item(build(0, IN_W'({OP_MOV_LD, 8'h04, 8'h25}), 3));                      // SIB, no base
    add_item(build(0, IN_W'({OP_ESC, 8'hAF, 8'h44, 8'h24, 8'h08}), 5));
    add_item(build(0, IN_W'({REX_LO | 8'h01, OP_ESC, 8'hB6, 8'h0C, 8'h8D}), 5));
    add_item(build(0, IN_W'({OP_GRP1_I8, 8'h00}), 2));
    add_item(build(0, IN_W'({OP_GRP1_I32, 8'h80}), 2));
    add_item(build(0, IN_W'({OP_GRP1_SI8, 8'h47}), 2));
    add_item(build(0, IN_W'({OP_GRP5, 8'h30}), 2));
    add_item(build(0, IN_W'({REX_HI, OP_TEST, 8'h3D}), 3));
    add_item(build(0, IN_W'({OP_NOP, 8'h06}), 2));                                // unknown op
    add_item(build(10, IN_W'({OP_XOR, 8'h01}), 2));                               // every prefix
    add_item(build(NUM_BYTES, '0, 0));                                            // all prefixes
    add_item(build(NUM_BYTES - 1, IN_W'(OP_MOV_LD), 1));                          // ModR/M past end
    add_item(build(NUM_BYTES - 2, IN_W'({OP_MOV_LD, 8'h01}), 2));                 // longest fit
    add_item(build(NUM_BYTES - 2, IN_W'({OP_MOV_LD, 8'h04}), 2));                 // SIB past end
    add_item(build(10, IN_W'({OP_GRP1_I32, 8'h80}), 2));                          // too long
    add_item('0);
    add_item('1);
    wait_drained();

    run_phase(0, 0, 250);
    run_phase(62, 0, 250);
    run_phase(0, 62, 250);
    run_phase(28, 28, 250);

    // output held off while the sender keeps offering, so the input backs up
    @(posedge clk);
    hold_long = 1'b1;
    run_phase(0, 0, 120);
    hold_long = 1'b0;

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d decodes: %0d VEX/EVEX, %0d with a memory base, %0d length zero",
             results_seen, n_vex, n_based, n_zero_len);
    $display("Traffic: free flow, sender gaps, receiver stalls, both, and a %0d-cycle hold",
             HOLD_CYCLES);
    if (mismatch_count == 0 && predicted_decodes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, predicted_decodes.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
